// ----- hw/rtl/spq_pkg.sv -----
`timescale 1ns / 1ps

package spq_pkg;

  // Default queue capacity
  localparam int DEPTH_DEF = 128;

  // Field widths
  localparam int VAL_W   = 32;
  localparam int PRIO_W  = 32;
  localparam int STAT_W  = 2;
  localparam int COUNT_W = 8;

  // Transaction opcodes
  typedef enum logic [0:0] {
    OP_INSERT = 1'b0,
    OP_REMOVE = 1'b1
  } opcode_t;

  // Result status codes
  typedef enum logic [STAT_W-1:0] {
    ST_DONE  = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2
  } status_t;

  // One queue entry
  typedef struct packed {
    logic signed [VAL_W-1:0]  value;
    logic signed [PRIO_W-1:0] prio;
  } entry_t;

  // Command broadcast to every cell of the row
  typedef struct packed {
    logic   ins;   // place ent in its sorted position
    logic   del;   // shift the row toward the head by one
    entry_t ent;
  } cmd_t;

endpackage

// ----- hw/rtl/spq_cell.sv -----
`timescale 1ns / 1ps

// One slot of the sorted row. The head slot holds the highest priority.
module spq_cell (
  input  logic            clk,
  input  spq_pkg::cmd_t   cmd,
  input  logic            occ,        // slot holds a live entry
  input  logic            left_keep,  // head-side neighbor keeps its entry
  input  spq_pkg::entry_t left_ent,
  input  spq_pkg::entry_t right_ent,
  output spq_pkg::entry_t ent,
  output logic            keep
);

  spq_pkg::entry_t ent_r;
  spq_pkg::entry_t ent_nxt;

  // Keep own entry on insert when it strictly outranks the new one;
  // equal priorities let the newer entry move ahead of this one.
  assign keep = occ && (ent_r.prio > cmd.ent.prio);

  // Take new entry at boundary, else move tailward; del moves headward
  always_comb begin
    ent_nxt = ent_r;
    if (cmd.ins) begin
      if (!keep) begin
        ent_nxt = left_keep ? cmd.ent : left_ent;
      end
    end else if (cmd.del) begin
      ent_nxt = right_ent;
    end
  end

  always_ff @(posedge clk) begin
    ent_r <= ent_nxt;
  end

  assign ent = ent_r;

endmodule

// ----- hw/rtl/sorted_priority_queue.sv -----
`timescale 1ns / 1ps

// Bounded priority queue of (value, signed priority) entries.
// Input: a transaction is taken at a rising edge with start high and busy
// low. in_opcode selects insert (place in_item_value / in_item_priority in
// sorted order) or remove (take the entry of highest priority; among equal
// priorities the most recently inserted one).
// Result: exactly one per transaction, shown for one cycle with out_strobe
// high, in the cycle after the transaction is taken. out_status reports done,
// refused because full, or refused because empty; out_entry_count is the
// number of entries held afterwards (low 8 bits); the removed entry appears
// on out_removed_value / out_removed_priority, zero when nothing was removed.
// Throughput: one transaction per cycle. Entries sit in a row of DEPTH cells
// with the highest priority at the head; every cell compares its own entry
// against the incoming one and takes from a neighbor, so busy stays low.
// Reset: synchronous, active low; empties the queue and drops any pending
// result. The receiver cannot stall; results must be taken when strobed.
module sorted_priority_queue #(
  parameter int DEPTH = spq_pkg::DEPTH_DEF
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             start,
  output logic                             busy,
  input  logic                             in_opcode,
  input  logic signed [spq_pkg::VAL_W-1:0]  in_item_value,
  input  logic signed [spq_pkg::PRIO_W-1:0] in_item_priority,
  output logic                             out_strobe,
  output logic [spq_pkg::STAT_W-1:0]        out_status,
  output logic [spq_pkg::COUNT_W-1:0]       out_entry_count,
  output logic signed [spq_pkg::VAL_W-1:0]  out_removed_value,
  output logic signed [spq_pkg::PRIO_W-1:0] out_removed_priority
);

  localparam int CW = $clog2(DEPTH + 1);

  logic [CW-1:0]   cnt_r;
  logic [CW-1:0]   cnt_nxt;
  logic            accept;
  logic            is_ins;
  logic            full;
  logic            empty;
  spq_pkg::cmd_t   cmd;
  spq_pkg::status_t stat_nxt;
  spq_pkg::entry_t rem_nxt;
  spq_pkg::entry_t cell_ent [DEPTH];
  logic            cell_keep [DEPTH];
  logic            cell_occ [DEPTH];
  logic [CW+spq_pkg::COUNT_W-1:0] cnt_ext;

  logic                       strobe_r;
  spq_pkg::status_t           status_r;
  logic [spq_pkg::COUNT_W-1:0] count_r;
  spq_pkg::entry_t            rem_r;

  // The row never stalls a transaction
  assign busy   = 1'b0;
  assign accept = start && !busy;
  assign is_ins = (spq_pkg::opcode_t'(in_opcode) == spq_pkg::OP_INSERT);
  assign full   = (cnt_r == CW'(DEPTH));
  assign empty  = (cnt_r == '0);

  // Decode transaction into a row command, status and new count
  always_comb begin
    cmd.ins       = 1'b0;
    cmd.del       = 1'b0;
    cmd.ent.value = in_item_value;
    cmd.ent.prio  = in_item_priority;
    stat_nxt      = spq_pkg::ST_DONE;
    cnt_nxt       = cnt_r;
    rem_nxt       = '0;
    if (accept) begin
      if (is_ins) begin
        if (full) begin
          stat_nxt = spq_pkg::ST_FULL;
        end else begin
          cmd.ins = 1'b1;
          cnt_nxt = cnt_r + 1'b1;
        end
      end else begin
        if (empty) begin
          stat_nxt = spq_pkg::ST_EMPTY;
        end else begin
          cmd.del = 1'b1;
          cnt_nxt = cnt_r - 1'b1;
          rem_nxt = cell_ent[0];
        end
      end
    end
  end

  // Row of cells, head at index 0
  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    spq_pkg::entry_t left_ent;
    spq_pkg::entry_t right_ent;
    logic            left_keep;

    assign cell_occ[i] = (cnt_r > CW'(i));

    if (i == 0) begin : g_head
      assign left_keep = 1'b1;
      assign left_ent  = '0;
    end else begin : g_mid
      assign left_keep = cell_keep[i-1];
      assign left_ent  = cell_ent[i-1];
    end

    if (i == DEPTH - 1) begin : g_tail
      assign right_ent = '0;
    end else begin : g_body
      assign right_ent = cell_ent[i+1];
    end

    spq_cell u_cell (
      .clk       (clk),
      .cmd       (cmd),
      .occ       (cell_occ[i]),
      .left_keep (left_keep),
      .left_ent  (left_ent),
      .right_ent (right_ent),
      .ent       (cell_ent[i]),
      .keep      (cell_keep[i])
    );
  end

  // Occupancy count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else begin
      cnt_r <= cnt_nxt;
    end
  end

  // Result strobe
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      strobe_r <= 1'b0;
    end else begin
      strobe_r <= accept;
    end
  end

  // Result payload
  assign cnt_ext = {{spq_pkg::COUNT_W{1'b0}}, cnt_nxt};

  always_ff @(posedge clk) begin
    if (accept) begin
      status_r <= stat_nxt;
      count_r  <= cnt_ext[spq_pkg::COUNT_W-1:0];
      rem_r    <= rem_nxt;
    end
  end

  assign out_strobe           = strobe_r;
  assign out_status           = status_r;
  assign out_entry_count      = count_r;
  assign out_removed_value    = rem_r.value;
  assign out_removed_priority = rem_r.prio;

  // Checks
  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CW'(DEPTH))
    else $error("entry count above capacity");

  a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> out_strobe)
    else $error("accepted transaction produced no result");

  a_ins_count: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && is_ins && !full) |=> (cnt_r == $past(cnt_r) + 1'b1))
    else $error("insert did not grow the queue");

  a_head_order: assert property (@(posedge clk) disable iff (!rst_n)
    (cnt_r >= CW'(2)) |-> (cell_ent[0].prio >= cell_ent[1].prio))
    else $error("head entries out of priority order");

  a_empty_status: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && !is_ins && empty) |=> (out_status == spq_pkg::ST_EMPTY))
    else $error("remove from empty queue not refused");

endmodule

// ----- test/testbench.sv -----
`timescale 1ns / 1ps

module testbench;
  import spq_pkg::*;

  localparam int QUEUE_DEPTH   = DEPTH_DEF;
  localparam int RANDOM_ITEMS  = 1200;
  localparam int CYCLE_LIMIT   = 200000;
  localparam int END_SETTLE    = 8;
  localparam int PRINT_LIMIT   = 40;

  // One pending insert/remove command plus its pacing controls
  typedef struct {
    opcode_t                  op;
    logic signed [VAL_W-1:0]  val;
    logic signed [PRIO_W-1:0] pri;
    int                       idle_pct;
    bit                       drain_first;
  } queue_cmd_t;

  // One expected result transaction
  typedef struct packed {
    logic [STAT_W-1:0]        status;
    logic [COUNT_W-1:0]       count;
    logic signed [VAL_W-1:0]  value;
    logic signed [PRIO_W-1:0] prio;
  } queue_result_t;

  // Mix of inserts and removes for one random segment
  typedef enum int {
    MIX_FILL,
    MIX_EMPTY,
    MIX_EVEN
  } mix_t;

  logic                      clk = 1'b0;
  logic                      rst_n = 1'b0;
  logic                      start = 1'b0;
  logic                      busy;
  logic                      in_opcode = OP_INSERT;
  logic signed [VAL_W-1:0]   in_item_value = '0;
  logic signed [PRIO_W-1:0]  in_item_priority = '0;
  logic                      out_strobe;
  logic [STAT_W-1:0]         out_status;
  logic [COUNT_W-1:0]        out_entry_count;
  logic signed [VAL_W-1:0]   out_removed_value;
  logic signed [PRIO_W-1:0]  out_removed_priority;

  queue_cmd_t    pending_cmds[$];
  queue_result_t expected_results[$];
  entry_t        sorted_entries[$];   // ascending priority, tail is highest
  bit            results_pending = 1'b0;
  int            error_count = 0;
  int            cycle_count = 0;

  sorted_priority_queue #(
    .DEPTH(QUEUE_DEPTH)
  ) u_dut (
    .clk                  (clk),
    .rst_n                (rst_n),
    .start                (start),
    .busy                 (busy),
    .in_opcode            (in_opcode),
    .in_item_value        (in_item_value),
    .in_item_priority     (in_item_priority),
    .out_strobe           (out_strobe),
    .out_status           (out_status),
    .out_entry_count      (out_entry_count),
    .out_removed_value    (out_removed_value),
    .out_removed_priority (out_removed_priority)
  );

  always #5 clk = ~clk;

  // Count every mismatch; print only the first few
  task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
    if (error_count < PRINT_LIMIT) begin
      $display("mismatch at cycle %0d: %s got %h expected %h", cycle_count, what, got, want);
    end
    error_count++;
  endtask

  // Apply one command to the sorted entry list and return its result
  function automatic queue_result_t apply_queue_cmd(opcode_t op, logic signed [VAL_W-1:0] val,
                                                   logic signed [PRIO_W-1:0] pri);
    queue_result_t res;
    entry_t        ent;
    int            pos;
    res = '{status: ST_DONE, count: '0, value: '0, prio: '0};
    if (op == OP_INSERT) begin
      if (sorted_entries.size() >= QUEUE_DEPTH) begin
        res.status = ST_FULL;
      end else begin
        // new entry goes after every entry of lower or equal priority
        pos = sorted_entries.size();
        while (pos > 0 && sorted_entries[pos-1].prio > pri) pos--;
        ent.value = val;
        ent.prio  = pri;
        sorted_entries.insert(pos, ent);
      end
    end else begin
      if (sorted_entries.size() == 0) begin
        res.status = ST_EMPTY;
      end else begin
        ent = sorted_entries.pop_back();
        res.value = ent.value;
        res.prio  = ent.prio;
      end
    end
    res.count = COUNT_W'(sorted_entries.size());
    return res;
  endfunction

  // Priorities: many small values for ties, some extremes, the rest anywhere
  function automatic logic signed [PRIO_W-1:0] rand_prio();
    logic signed [PRIO_W-1:0] p;
    case ($urandom_range(0, 9))
      0, 1, 2, 3: begin
        p = $urandom_range(0, 7);
        p = p - 4;
      end
      4: begin
        case ($urandom_range(0, 3))
          0: p = 32'sh7FFF_FFFF;
          1: p = 32'sh8000_0000;
          2: p = '0;
          default: p = -1;
        endcase
      end
      default: p = $urandom;
    endcase
    return p;
  endfunction

  task automatic add_cmd(opcode_t op, logic signed [VAL_W-1:0] val,
                         logic signed [PRIO_W-1:0] pri, int idle_pct, bit drain_first);
    queue_cmd_t c;
    c.op          = op;
    c.val         = val;
    c.pri         = pri;
    c.idle_pct    = idle_pct;
    c.drain_first = drain_first;
    pending_cmds.push_back(c);
  endtask

  // Driver: holds start with the current transaction until it is taken
  always @(posedge clk) begin : drive_cmds
    logic       next_start;
    bit         took;
    queue_cmd_t c;
    next_start = start;
    took       = start && !busy;
    if (!rst_n) begin
      next_start = 1'b0;
    end else if (took || !start) begin
      next_start = 1'b0;
      if (pending_cmds.size() != 0) begin
        c = pending_cmds[0];
        if (c.drain_first && (took || results_pending)) begin
          // hold off until every outstanding result is back
        end else if ($urandom_range(0, 99) >= c.idle_pct) begin
          in_opcode        <= c.op;
          in_item_value    <= c.val;
          in_item_priority <= c.pri;
          void'(pending_cmds.pop_front());
          next_start = 1'b1;
        end
      end
    end
    start <= next_start;
  end

  // Monitor: predict on every taken transaction, check every strobed result
  always @(posedge clk) begin : check_results
    queue_result_t got;
    queue_result_t want;
    if (rst_n) begin
      if (out_strobe) begin
        got = '{status: out_status, count: out_entry_count,
                value: out_removed_value, prio: out_removed_priority};
        if (expected_results.size() == 0) begin
          report_mismatch("unexpected result", 64'({out_status, out_entry_count}),
                          {out_removed_value, out_removed_priority});
        end else begin
          want = expected_results.pop_front();
          if (got.status !== want.status)
            report_mismatch("status", 64'(got.status), 64'(want.status));
          if (got.count !== want.count)
            report_mismatch("entry_count", 64'(got.count), 64'(want.count));
          if (got.value !== want.value)
            report_mismatch("removed_value", 64'(got.value), 64'(want.value));
          if (got.prio !== want.prio)
            report_mismatch("removed_priority", 64'(got.prio), 64'(want.prio));
        end
      end
      if (start && !busy) begin
        expected_results.push_back(apply_queue_cmd(opcode_t'(in_opcode), in_item_value,
                                                   in_item_priority));
      end
    end
    results_pending <= (expected_results.size() != 0);
  end

  // Timeout guard
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  // Stimulus, reset and end of run
  initial begin : stimulus
    int   random_count;
    int   seg;
    int   seg_len;
    int   ins_pct;
    int   idle_pct;
    mix_t mix;

    // directed: empty remove, field extremes, ties, drain to empty
    add_cmd(OP_REMOVE, $urandom, $urandom, 0, 1'b0);
    add_cmd(OP_INSERT, 32'sh7FFF_FFFF, 32'sh0000_0000, 0, 1'b0);
    add_cmd(OP_INSERT, 32'sh8000_0000, 32'sh7FFF_FFFF, 0, 1'b0);
    add_cmd(OP_INSERT, -1, 32'sh8000_0000, 0, 1'b0);
    add_cmd(OP_INSERT, 5, 0, 0, 1'b0);
    add_cmd(OP_INSERT, 6, 0, 0, 1'b0);
    add_cmd(OP_INSERT, 0, -1, 0, 1'b0);
    add_cmd(OP_INSERT, 32'sh5555_5555, 1, 0, 1'b0);
    repeat (7) add_cmd(OP_REMOVE, $urandom, $urandom, 0, 1'b0);
    add_cmd(OP_REMOVE, $urandom, $urandom, 0, 1'b0);
    // equal priorities come out newest first
    add_cmd(OP_INSERT, 1, -5, 0, 1'b1);
    add_cmd(OP_INSERT, 2, -5, 0, 1'b0);
    add_cmd(OP_INSERT, 3, -5, 0, 1'b0);
    add_cmd(OP_INSERT, 32'shAAAA_AAAA, -6, 0, 1'b0);
    repeat (5) add_cmd(OP_REMOVE, $urandom, $urandom, 0, 1'b0);

    // random segments: fill toward full, drain toward empty, or balanced
    random_count = 0;
    seg = 0;
    while (random_count < RANDOM_ITEMS) begin
      if (seg == 0) mix = MIX_FILL;
      else if (seg == 1) mix = MIX_EMPTY;
      else mix = mix_t'($urandom_range(0, 2));
      case (mix)
        MIX_FILL:  ins_pct = 92;
        MIX_EMPTY: ins_pct = 8;
        default:   ins_pct = 50;
      endcase
      case (seg % 3)
        0:       idle_pct = 0;
        1:       idle_pct = 66;
        default: idle_pct = 13;
      endcase
      seg_len = (seg == 0) ? 180 : $urandom_range(60, 200);
      for (int i = 0; i < seg_len; i++) begin
        add_cmd(($urandom_range(0, 99) < ins_pct) ? OP_INSERT : OP_REMOVE,
                $urandom, rand_prio(), idle_pct, (i == 0) && (seg % 2 == 1));
      end
      random_count += seg_len;
      seg++;
    end

    rst_n = 1'b0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    while (pending_cmds.size() != 0 || start || expected_results.size() != 0)
      @(negedge clk);
    repeat (END_SETTLE) @(negedge clk);

    if (expected_results.size() != 0)
      report_mismatch("results never arrived", 64'(expected_results.size()), 64'(0));
    if (error_count == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
